FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/msp_pkg.sv
// Shared types, codes and tables of the SysEx command parser.
package msp_pkg;

   localparam int MSP_QUEUE_DEPTH = 2;

   // result status codes
   localparam logic [1:0] MSP_STAT_REALTIME = 2'd0;
   localparam logic [1:0] MSP_STAT_REJECT   = 2'd1;
   localparam logic [1:0] MSP_STAT_CONSUMED = 2'd2;
   localparam logic [1:0] MSP_STAT_TIMEOUT  = 2'd3;

   localparam logic       MSP_MODE_TIMEOUT  = 1'b1;

   localparam logic [2:0] MSP_HDR_LEN       = 3'd5;
   localparam logic [7:0] MSP_SYSEX_END     = 8'hF7;
   localparam logic [7:0] MSP_REALTIME_MIN  = 8'hF8;
   localparam logic [6:0] MSP_CMD_PING      = 7'h0F;
   localparam logic [6:0] MSP_CMD_IGNORE    = 7'h0E;
   localparam logic [7:0] MSP_CODE_ACK      = 8'h0F;
   localparam logic [7:0] MSP_CODE_DISACK   = 8'h0E;
   localparam logic [7:0] MSP_ARG_ACK       = 8'h00;
   localparam logic [7:0] MSP_ARG_DISACK    = 8'h0C;

   // beat positions inside a reply
   localparam logic [3:0] MSP_BEAT_DEV      = 4'd5;
   localparam logic [3:0] MSP_BEAT_CODE     = 4'd6;
   localparam logic [3:0] MSP_BEAT_ARG      = 4'd7;
   localparam logic [3:0] MSP_BEAT_END      = 4'd8;

   typedef struct packed {
      logic       reply;   // 1: nine-beat reply, 0: single plain result
      logic       ack;     // reply kind: 1 ACK, 0 DISACK
      logic [1:0] status;
      logic [7:0] port;
   } msp_job_type;

   function automatic logic [7:0] msp_hdr_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'hF0;
         3'd1:    b = 8'h00;
         3'd2:    b = 8'h00;
         3'd3:    b = 8'h7E;
         3'd4:    b = 8'h4D;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: hdl/midi_sysex_command_parser.sv
// Throughput: one input item per cycle while the job queue is not full; a reply
// drains as nine result beats, one per cycle while rsp_ready is high, and the
// two-entry job queue back-pressures the input while it drains.
// Reset (synchronous): parser state, locked port, queue and rsp_valid cleared;
// device_id returns to 0.
module midi_sysex_command_parser import msp_pkg::*; #(
   parameter int QUEUE_DEPTH = MSP_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_port,
   input  logic [7:0] req_midi_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_reply_byte,
   output logic [7:0] rsp_reply_port,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_device_id
);

   logic [6:0]  device_id_ff;
   logic        push;
   logic        pop;
   logic        full;
   logic        empty;
   msp_job_type push_job;
   msp_job_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 7'd0;
      end else if (csr_valid && csr_ready) begin
         device_id_ff <= csr_device_id;
      end
   end

   msp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_port      (req_port),
      .req_midi_byte (req_midi_byte),
      .device_id     (device_id_ff),
      .push          (push),
      .push_job      (push_job),
      .full          (full)
   );

   msp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   msp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .device_id      (device_id_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_port (rsp_reply_port),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: hdl/msp_front.sv
// Front end: parser state, message classification and job generation.
module msp_front import msp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_port,
   input  logic [7:0]  req_midi_byte,
   input  logic [6:0]  device_id,
   output logic        push,
   output msp_job_type push_job,
   input  logic        full
);

   logic [2:0] hdr_cnt_ff, hdr_cnt_in;
   logic       in_msg_ff, in_msg_in;
   logic       have_cmd_ff, have_cmd_in;
   logic       extra_ff, extra_in;
   logic [6:0] cmd_ff, cmd_in;
   logic [7:0] lock_port_ff, lock_port_in;

   logic [2:0] hdr_nxt;
   logic       hdr_match;
   logic       same_port;

   assign req_ready = !full;
   assign push      = req_valid && req_ready;
   assign hdr_nxt   = hdr_cnt_ff + 3'd1;
   assign same_port = (req_port == lock_port_ff);
   assign hdr_match = (hdr_cnt_ff < MSP_HDR_LEN) ?
                      (req_midi_byte == msp_hdr_byte(hdr_cnt_ff)) :
                      (req_midi_byte == {1'b0, device_id});

   always_comb begin
      hdr_cnt_in      = hdr_cnt_ff;
      in_msg_in       = in_msg_ff;
      have_cmd_in     = have_cmd_ff;
      extra_in        = extra_ff;
      cmd_in          = cmd_ff;
      lock_port_in    = lock_port_ff;
      push_job.reply  = 1'b0;
      push_job.ack    = 1'b0;
      push_job.status = MSP_STAT_CONSUMED;
      push_job.port   = req_port;

      if (req_mode == MSP_MODE_TIMEOUT) begin
         push_job.status = MSP_STAT_TIMEOUT;
         if (in_msg_ff && same_port) begin
            hdr_cnt_in  = 3'd0;
            in_msg_in   = 1'b0;
            have_cmd_in = 1'b0;
            extra_in    = 1'b0;
            cmd_in      = 7'd0;
         end
      end else if (req_midi_byte >= MSP_REALTIME_MIN) begin
         push_job.status = MSP_STAT_REALTIME;
      end else if (in_msg_ff && !same_port) begin
         push_job.status = MSP_STAT_REJECT;
      end else begin
         lock_port_in = req_port;
         if (!in_msg_ff) begin
            if (hdr_match) begin
               hdr_cnt_in = hdr_nxt;
               if (hdr_nxt > MSP_HDR_LEN) begin
                  in_msg_in = 1'b1;
               end
            end else begin
               hdr_cnt_in  = 3'd0;
               in_msg_in   = 1'b0;
               have_cmd_in = 1'b0;
               extra_in    = 1'b0;
               cmd_in      = 7'd0;
            end
         end else if (req_midi_byte[7]) begin
            // status byte ends the message; F7 may trigger the reply
            if (req_midi_byte == MSP_SYSEX_END && have_cmd_ff) begin
               if (cmd_ff == MSP_CMD_PING) begin
                  if (!extra_ff) begin
                     push_job.reply = 1'b1;
                     push_job.ack   = 1'b1;
                  end
               end else if (cmd_ff != MSP_CMD_IGNORE) begin
                  push_job.reply = 1'b1;
               end
            end
            hdr_cnt_in  = 3'd0;
            in_msg_in   = 1'b0;
            have_cmd_in = 1'b0;
            extra_in    = 1'b0;
            cmd_in      = 7'd0;
         end else if (!have_cmd_ff) begin
            have_cmd_in = 1'b1;
            cmd_in      = req_midi_byte[6:0];
            if (req_midi_byte[6:0] == MSP_CMD_PING) begin
               extra_in = 1'b0;
            end else if (req_midi_byte[6:0] != MSP_CMD_IGNORE) begin
               push_job.reply = 1'b1;
               hdr_cnt_in     = 3'd0;
               in_msg_in      = 1'b0;
               have_cmd_in    = 1'b0;
               extra_in       = 1'b0;
               cmd_in         = 7'd0;
            end
         end else begin
            if (cmd_ff == MSP_CMD_PING) begin
               extra_in = 1'b1;
            end else if (cmd_ff != MSP_CMD_IGNORE) begin
               push_job.reply = 1'b1;
               hdr_cnt_in     = 3'd0;
               in_msg_in      = 1'b0;
               have_cmd_in    = 1'b0;
               extra_in       = 1'b0;
               cmd_in         = 7'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= 3'd0;
         in_msg_ff    <= 1'b0;
         have_cmd_ff  <= 1'b0;
         extra_ff     <= 1'b0;
         cmd_ff       <= 7'd0;
         lock_port_ff <= 8'd0;
      end else if (push) begin
         hdr_cnt_ff   <= hdr_cnt_in;
         in_msg_ff    <= in_msg_in;
         have_cmd_ff  <= have_cmd_in;
         extra_ff     <= extra_in;
         cmd_ff       <= cmd_in;
         lock_port_ff <= lock_port_in;
      end
   end

endmodule

FILE: hdl/msp_queue.sv
// Short job queue between the parser front end and the reply back end.
module msp_queue import msp_pkg::*; #(
   parameter int DEPTH = MSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  msp_job_type push_job,
   output logic        full,
   input  logic        pop,
   output msp_job_type head,
   output logic        empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   msp_job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/msp_back.sv
// Back end: expands queued jobs into result beats behind an output register.
module msp_back import msp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  msp_job_type head,
   input  logic        empty,
   output logic        pop,
   input  logic [6:0]  device_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_reply_byte,
   output logic [7:0]  rsp_reply_port,
   output logic        rsp_last
);

   logic [3:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   logic [1:0] status_ff;
   logic       has_ff;
   logic [7:0] byte_ff;
   logic [7:0] port_ff;
   logic       last_ff;

   logic       slot_free;
   logic       load;
   logic       last_beat;
   logic [7:0] beat_byte;

   assign slot_free = !valid_ff || rsp_ready;
   assign load      = slot_free && !empty;
   assign last_beat = !head.reply || (beat_ff == MSP_BEAT_END);
   assign pop       = load && last_beat;

   always_comb begin
      case (beat_ff)
         MSP_BEAT_DEV:  beat_byte = {1'b0, device_id};
         MSP_BEAT_CODE: beat_byte = head.ack ? MSP_CODE_ACK : MSP_CODE_DISACK;
         MSP_BEAT_ARG:  beat_byte = head.ack ? MSP_ARG_ACK : MSP_ARG_DISACK;
         MSP_BEAT_END:  beat_byte = MSP_SYSEX_END;
         default:       beat_byte = msp_hdr_byte(beat_ff[2:0]);
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = last_beat ? 4'd0 : beat_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= head.status;
         has_ff    <= head.reply;
         byte_ff   <= head.reply ? beat_byte : 8'd0;
         port_ff   <= head.reply ? head.port : 8'd0;
         last_ff   <= last_beat;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_reply_byte = byte_ff;
   assign rsp_reply_port = port_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: hdl/msp_checker.sv
// Port-level checker for the SysEx command parser, with its bind.
`include "assert_macros.svh"

module msp_checker import msp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_has_byte,
   input logic [7:0] rsp_reply_byte,
   input logic [7:0] rsp_reply_port,
   input logic       rsp_last
);

   `MSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_has_byte) && $stable(rsp_reply_byte) && $stable(rsp_reply_port) && $stable(rsp_last), "rsp beat changed while stalled")
   `MSP_ASSERT_NOW(a_reply_status, rsp_valid && rsp_has_byte, rsp_status == MSP_STAT_CONSUMED, "reply beat without consumed status")
   `MSP_ASSERT_NOW(a_plain_shape, rsp_valid && !rsp_has_byte, rsp_last && rsp_reply_byte == 8'd0 && rsp_reply_port == 8'd0, "plain result not a single zeroed beat")
   `MSP_ASSERT_NEXT(a_reply_burst, rsp_valid && rsp_ready && rsp_has_byte && !rsp_last, rsp_valid && rsp_has_byte && rsp_reply_port == $past(rsp_reply_port), "reply burst broken")

endmodule

bind midi_sysex_command_parser msp_checker u_msp_checker (.*);

FILE: dv/midi_sysex_command_parser_tb.sv
// Self-checking testbench for the SysEx command parser: random MIDI traffic and reply checks.
module midi_sysex_command_parser_tb import msp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic       MODE_BYTE = 1'b0;
   localparam logic [7:0] SYSEX_HDR [0:4] = '{8'hF0, 8'h00, 8'h00, 8'h7E, 8'h4D};

   typedef struct packed {
      logic [1:0] status;
      logic       has_byte;
      logic [7:0] reply_byte;
      logic [7:0] reply_port;
      logic       last;
   } reply_beat_type;

   // Tracks the parser state, builds the expected result beats and checks them.
   class sysex_reply_tracker;
      logic [6:0]     dev_id      = '0;
      logic [2:0]     hdr_cnt     = '0;
      logic           in_msg      = 1'b0;
      logic           have_cmd    = 1'b0;
      logic           extra_ping  = 1'b0;
      logic [6:0]     cmd         = '0;
      logic [7:0]     lock_port   = '0;
      reply_beat_type expected_beats [$];
      int             mismatches  = 0;

      function void set_device_id(logic [6:0] id);
         dev_id = id;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void close_msg();
         hdr_cnt    = '0;
         in_msg     = 1'b0;
         have_cmd   = 1'b0;
         extra_ping = 1'b0;
         cmd        = '0;
      endfunction

      function void push_plain(logic [1:0] status);
         expected_beats.push_back(reply_beat_type'{status, 1'b0, 8'h00, 8'h00, 1'b1});
      endfunction

      function void push_reply(logic [7:0] port, logic [7:0] code, logic [7:0] arg);
         logic [7:0] msg [9];
         for (int i = 0; i < 5; i++) msg[i] = SYSEX_HDR[i];
         msg[5] = {1'b0, dev_id};
         msg[6] = code;
         msg[7] = arg;
         msg[8] = MSP_SYSEX_END;
         for (int i = 0; i < 9; i++)
            expected_beats.push_back(
               reply_beat_type'{MSP_STAT_CONSUMED, 1'b1, msg[i], port, i == 8});
      endfunction

      function void accept_item(logic mode, logic [7:0] port, logic [7:0] b);
         logic [7:0] want;
         logic       replied;
         if (mode == MSP_MODE_TIMEOUT) begin
            if (in_msg && port == lock_port) close_msg();
            push_plain(MSP_STAT_TIMEOUT);
            return;
         end
         if (b >= MSP_REALTIME_MIN) begin
            push_plain(MSP_STAT_REALTIME);
            return;
         end
         if (in_msg && port != lock_port) begin
            push_plain(MSP_STAT_REJECT);
            return;
         end
         lock_port = port;
         if (!in_msg) begin
            want = (hdr_cnt < MSP_HDR_LEN) ? SYSEX_HDR[hdr_cnt] : {1'b0, dev_id};
            if (b != want) begin
               close_msg();
            end else begin
               hdr_cnt++;
               if (hdr_cnt > MSP_HDR_LEN) in_msg = 1'b1;
            end
            push_plain(MSP_STAT_CONSUMED);
            return;
         end
         if (b[7]) begin
            replied = 1'b0;
            if (b == MSP_SYSEX_END && have_cmd) begin
               if (cmd == MSP_CMD_PING) begin
                  if (!extra_ping) begin
                     push_reply(port, MSP_CODE_ACK, MSP_ARG_ACK);
                     replied = 1'b1;
                  end
               end else if (cmd != MSP_CMD_IGNORE) begin
                  push_reply(port, MSP_CODE_DISACK, MSP_ARG_DISACK);
                  replied = 1'b1;
               end
            end
            close_msg();
            if (!replied) push_plain(MSP_STAT_CONSUMED);
            return;
         end
         // data byte: the first one is the command
         if (!have_cmd) begin
            have_cmd = 1'b1;
            cmd      = b[6:0];
         end else if (cmd == MSP_CMD_PING) begin
            extra_ping = 1'b1;
         end
         if (cmd != MSP_CMD_PING && cmd != MSP_CMD_IGNORE) begin
            close_msg();
            push_reply(port, MSP_CODE_DISACK, MSP_ARG_DISACK);
         end else begin
            push_plain(MSP_STAT_CONSUMED);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(logic [1:0] status, logic has_byte, logic [7:0] rbyte,
                               logic [7:0] rport, logic last);
         reply_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: status %0d byte 0x%02h", status, rbyte);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("status", 8'(want.status), 8'(status));
         compare_field("has_byte", 8'(want.has_byte), 8'(has_byte));
         compare_field("reply_byte", want.reply_byte, rbyte);
         compare_field("reply_port", want.reply_port, rport);
         compare_field("last", 8'(want.last), 8'(last));
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic       req_mode       = 1'b0;
   logic [7:0] req_port       = '0;
   logic [7:0] req_midi_byte  = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [1:0] rsp_status;
   logic       rsp_has_byte;
   logic [7:0] rsp_reply_byte;
   logic [7:0] rsp_reply_port;
   logic       rsp_last;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_device_id  = '0;

   sysex_reply_tracker replies;
   logic [6:0] cur_dev    = '0;
   int         burst_left = 0;
   int         msg_items  = 0;
   int         stall_cycle = 0;
   int         stall_hold  = 0;

   midi_sysex_command_parser u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_port       (req_port),
      .req_midi_byte  (req_midi_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_reply_byte (rsp_reply_byte),
      .rsp_reply_port (rsp_reply_port),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_device_id  (csr_device_id)
   );

   always #5 clock = ~clock;

   // receiver: rotates through always-ready, random, periodic and long-stall stretches
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle >> 7) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(99) < 70);
         2: rsp_ready <= (stall_cycle % 3 != 2);
         default: begin
            if (stall_hold > 0) begin
               rsp_ready  <= 1'b0;
               stall_hold <= stall_hold - 1;
            end else if ($urandom_range(9) == 0) begin
               rsp_ready  <= 1'b0;
               stall_hold <= $urandom_range(12, 4);
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) replies.accept_item(req_mode, req_port, req_midi_byte);
         if (rsp_valid && rsp_ready)
            replies.check_beat(rsp_status, rsp_has_byte, rsp_reply_byte, rsp_reply_port,
                               rsp_last);
         if (csr_valid && csr_ready) replies.set_device_id(csr_device_id);
      end
   end

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [7:0] pick_port();
      int p;
      p = $urandom_range(9);
      if (p < 5) return rand_byte(0, 1);
      if (p < 9) return rand_byte(0, 255);
      return 8'hFF;
   endfunction

   task automatic send_item(input logic mode, input logic [7:0] port, input logic [7:0] b);
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_port      <= port;
      req_midi_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender works in bursts with random gaps between them
   task automatic send_paced(input logic mode, input logic [7:0] port, input logic [7:0] b);
      send_item(mode, port, b);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(15);
      end
   endtask

   task automatic send_msg_byte(input logic [7:0] port, input logic [7:0] b);
      send_paced(MODE_BYTE, port, b);
      msg_items++;
   endtask

   // occasional realtime byte, timeout elsewhere or (inside a message) foreign-port byte
   task automatic stray_item(input logic [7:0] port, input logic msg_open);
      int         pick;
      logic [7:0] other;
      pick  = $urandom_range(11);
      other = port ^ rand_byte(1, 255);
      if (pick == 0) send_paced(MODE_BYTE, rand_byte(0, 255), rand_byte(8'hF8, 8'hFF));
      else if (pick == 1) send_paced(MSP_MODE_TIMEOUT, other, rand_byte(0, 255));
      else if (pick == 2 && msg_open) send_paced(MODE_BYTE, other, rand_byte(0, 255));
   endtask

   task automatic send_sysex(input logic [7:0] port);
      int         pick;
      int         n_data;
      logic [7:0] cmd_b;
      for (int i = 0; i < 5; i++) begin
         stray_item(port, 1'b0);
         send_msg_byte(port, ($urandom_range(39) == 0) ? rand_byte(0, 255) : SYSEX_HDR[i]);
      end
      stray_item(port, 1'b0);
      send_msg_byte(port, ($urandom_range(9) == 0) ? rand_byte(0, 255) : {1'b0, cur_dev});
      pick = $urandom_range(19);
      // a few messages carry no command at all
      if (pick < 18) begin
         if (pick < 8) cmd_b = {1'b0, MSP_CMD_PING};
         else if (pick < 12) cmd_b = {1'b0, MSP_CMD_IGNORE};
         else cmd_b = rand_byte(0, 127);
         stray_item(port, 1'b1);
         send_msg_byte(port, cmd_b);
         pick   = $urandom_range(9);
         n_data = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
         repeat (n_data) begin
            stray_item(port, 1'b1);
            send_msg_byte(port, rand_byte(0, 127));
         end
      end
      stray_item(port, 1'b1);
      pick = $urandom_range(9);
      if (pick < 7) send_msg_byte(port, MSP_SYSEX_END);
      else if (pick == 7) send_msg_byte(port, rand_byte(8'h80, 8'hF6));
      else if (pick == 8) send_paced(MSP_MODE_TIMEOUT, port, rand_byte(0, 255));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies.pending() != 0) @(posedge clock);
   endtask

   task automatic write_device_id(input logic [6:0] id);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_device_id <= id;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_dev = id;
   endtask

   initial begin
      int dev_pick;
      int phase_start;
      replies = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(MSP_MODE_TIMEOUT, 8'h00, 8'hFF);
      send_item(MODE_BYTE, 8'hAA, MSP_REALTIME_MIN);
      send_item(MODE_BYTE, 8'h55, 8'hFF);
      // broken header; the next byte must not restart matching
      send_item(MODE_BYTE, 8'h10, SYSEX_HDR[0]);
      send_item(MODE_BYTE, 8'h10, 8'h01);
      send_item(MODE_BYTE, 8'h10, SYSEX_HDR[1]);
      // ping with stray traffic inside the open message
      for (int i = 0; i < 5; i++) send_item(MODE_BYTE, 8'hFF, SYSEX_HDR[i]);
      send_item(MODE_BYTE, 8'hFF, 8'h00);
      send_item(MODE_BYTE, 8'hFF, {1'b0, MSP_CMD_PING});
      send_item(MODE_BYTE, 8'h00, 8'h7F);
      send_item(MSP_MODE_TIMEOUT, 8'h01, 8'h00);
      send_item(MODE_BYTE, 8'hFF, 8'hFA);
      send_item(MODE_BYTE, 8'hFF, MSP_SYSEX_END);
      // unknown command answers at once
      for (int i = 0; i < 5; i++) send_item(MODE_BYTE, 8'h00, SYSEX_HDR[i]);
      send_item(MODE_BYTE, 8'h00, 8'h00);
      send_item(MODE_BYTE, 8'h00, 8'h7F);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) dev_pick = 127;
         else if (phase == 1) dev_pick = 0;
         else dev_pick = $urandom_range(127);
         write_device_id(dev_pick[6:0]);
         phase_start = msg_items;
         while (msg_items - phase_start < 18) begin
            if ($urandom_range(9) < 8) begin
               send_sysex(pick_port());
            end else begin
               repeat ($urandom_range(4, 1))
                  send_paced(1'($urandom_range(1)), rand_byte(0, 255), rand_byte(0, 255));
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (replies.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/msp_pkg.sv
hdl/msp_front.sv
hdl/msp_queue.sv
hdl/msp_back.sv
hdl/midi_sysex_command_parser.sv
hdl/msp_checker.sv
dv/midi_sysex_command_parser_tb.sv
